// ===== design/drsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drsd_pkg: shared types and constants of the delta RLE sprite decoder
// Command word between the stream parser and the span engine, result word,
// address and queue sizing.
// ----------------------------------------------------------------------------
package drsd_pkg;

    localparam int ADDR_BITS  = 20;
    localparam int DEST_W     = 20;
    localparam int LEN_W      = 7;
    localparam int OP_W       = 18;
    localparam int PROD_W     = 2 * OP_W;
    localparam int BS_W       = ADDR_BITS + 1;
    localparam int HDR_BYTES  = 8;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    localparam logic [DEST_W-1:0] DEST_MASK = DEST_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [BS_W-1:0]   BUF_CAP   = BS_W'(64'd1 << ADDR_BITS);
    localparam logic [BS_W-1:0]   HDR_SIZE  = BS_W'(HDR_BYTES);

    typedef enum logic [1:0] {
        CMD_HDR,
        CMD_PIX,
        CMD_SETPTR,
        CMD_DONE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind               kind;
        logic                    fin;
        logic signed [OP_W-1:0]  op_a;
        logic signed [OP_W-1:0]  op_b;
        logic [15:0]             x_off;
        logic [LEN_W-1:0]        len;
        logic [7:0]              val;
    } t_cmd;

    typedef struct packed {
        logic [DEST_W-1:0] dest_address;
        logic [LEN_W-1:0]  span_length;
        logic [7:0]        pixel_value;
        logic              out_of_range;
        logic              image_done;
    } t_result;

endpackage
`default_nettype wire

// ===== design/drsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drsd_front: stream parser
// Walks header, control words, offsets and run bytes; issues one span
// command per byte that produces or prepares a write.
// ----------------------------------------------------------------------------
module drsd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_image_start,
    output drsd_pkg::t_cmd      o_cmd,
    output logic                o_cmd_push
);
    import drsd_pkg::*;

    typedef enum logic [3:0] {
        PH_WAIT, PH_HDR, PH_CTRL_LO, PH_CTRL_HI, PH_X_LO, PH_X_HI, PH_Y_LO,
        PH_Y_HI, PH_LIT, PH_RUNHDR, PH_FILLVAL, PH_RUNLIT, PH_DONE
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [2:0]    r_cnt, n_cnt;
    logic [7:0]    r_low, n_low;
    logic [15:0]   r_hw0, n_hw0, r_hw1, n_hw1, r_hw2, n_hw2;
    logic [15:0]   r_width, n_width;
    logic          r_rle, n_rle;
    logic [14:0]   r_chunk_rem, n_chunk_rem;
    logic [6:0]    r_run_rem, n_run_rem;
    logic [15:0]   r_xoff, n_xoff;

    always_comb begin
        t_phase      eff_phase;
        logic [2:0]  idx;
        logic [15:0] word;
        logic [15:0] w16;
        logic [6:0]  rl;
        logic [14:0] rem_new;
        logic [6:0]  run_new;

        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_low       = r_low;
        n_hw0       = r_hw0;
        n_hw1       = r_hw1;
        n_hw2       = r_hw2;
        n_width     = r_width;
        n_rle       = r_rle;
        n_chunk_rem = r_chunk_rem;
        n_run_rem   = r_run_rem;
        n_xoff      = r_xoff;
        o_cmd       = '0;
        o_cmd_push  = 1'b0;

        eff_phase = i_image_start ? PH_HDR : r_phase;
        idx       = i_image_start ? 3'd0 : r_cnt;
        word      = {i_data_byte, r_low};
        w16       = r_hw2 - r_hw0 + 16'd1;
        rl        = i_data_byte[7:1];
        rem_new   = (r_chunk_rem > 15'(rl)) ? r_chunk_rem - 15'(rl) : 15'd0;
        run_new   = (r_run_rem != 7'd0) ? r_run_rem - 7'd1 : 7'd0;

        if (i_accept) begin
            unique case (eff_phase)
                PH_HDR: begin
                    o_cmd_push   = 1'b1;
                    o_cmd.kind   = CMD_HDR;
                    o_cmd.x_off  = 16'(idx);
                    o_cmd.len    = LEN_W'(1);
                    o_cmd.val    = i_data_byte;
                    if (idx[0]) begin
                        unique case (idx[2:1])
                            2'd0: n_hw0 = word;
                            2'd1: n_hw1 = word;
                            2'd2: n_hw2 = word;
                            2'd3: ;
                        endcase
                    end else begin
                        n_low = i_data_byte;
                    end
                    if (idx == 3'd7) begin
                        o_cmd.fin  = 1'b1;
                        o_cmd.op_a = OP_W'($signed(w16));
                        o_cmd.op_b = OP_W'($signed(word)) - OP_W'($signed(r_hw1))
                                     + OP_W'(1);
                        n_width    = w16;
                        n_cnt      = 3'd0;
                        n_phase    = PH_CTRL_LO;
                    end else begin
                        n_cnt   = idx + 3'd1;
                        n_phase = PH_HDR;
                    end
                end
                PH_CTRL_LO: begin
                    n_low   = i_data_byte;
                    n_phase = PH_CTRL_HI;
                end
                PH_CTRL_HI: begin
                    if (word == 16'd0) begin
                        o_cmd_push = 1'b1;
                        o_cmd.kind = CMD_DONE;
                        n_phase    = PH_DONE;
                    end else begin
                        n_rle       = word[0];
                        n_chunk_rem = word[15:1];
                        n_phase     = PH_X_LO;
                    end
                end
                PH_X_LO: begin
                    n_low   = i_data_byte;
                    n_phase = PH_X_HI;
                end
                PH_X_HI: begin
                    n_xoff  = word;
                    n_phase = PH_Y_LO;
                end
                PH_Y_LO: begin
                    n_low   = i_data_byte;
                    n_phase = PH_Y_HI;
                end
                PH_Y_HI: begin
                    o_cmd_push  = 1'b1;
                    o_cmd.kind  = CMD_SETPTR;
                    o_cmd.op_a  = OP_W'($signed(word));
                    o_cmd.op_b  = OP_W'($signed(r_width));
                    o_cmd.x_off = r_xoff;
                    if (r_chunk_rem == 15'd0) begin
                        n_phase = PH_CTRL_LO;
                    end else begin
                        n_phase = r_rle ? PH_RUNHDR : PH_LIT;
                    end
                end
                PH_LIT: begin
                    o_cmd_push = 1'b1;
                    o_cmd.kind = CMD_PIX;
                    o_cmd.len  = LEN_W'(1);
                    o_cmd.val  = i_data_byte;
                    if (r_chunk_rem <= 15'd1) begin
                        n_chunk_rem = 15'd0;
                        n_phase     = PH_CTRL_LO;
                    end else begin
                        n_chunk_rem = r_chunk_rem - 15'd1;
                    end
                end
                PH_RUNHDR: begin
                    n_run_rem   = rl;
                    n_chunk_rem = rem_new;
                    if (i_data_byte[0]) begin
                        n_phase = PH_FILLVAL;
                    end else if (rl != 7'd0) begin
                        n_phase = PH_RUNLIT;
                    end else begin
                        n_phase = (rem_new == 15'd0) ? PH_CTRL_LO : PH_RUNHDR;
                    end
                end
                PH_FILLVAL: begin
                    n_run_rem = 7'd0;
                    n_phase   = (r_chunk_rem == 15'd0) ? PH_CTRL_LO : PH_RUNHDR;
                    if (r_run_rem != 7'd0) begin
                        o_cmd_push = 1'b1;
                        o_cmd.kind = CMD_PIX;
                        o_cmd.len  = r_run_rem;
                        o_cmd.val  = i_data_byte;
                    end
                end
                PH_RUNLIT: begin
                    o_cmd_push = 1'b1;
                    o_cmd.kind = CMD_PIX;
                    o_cmd.len  = LEN_W'(1);
                    o_cmd.val  = i_data_byte;
                    n_run_rem  = run_new;
                    if (run_new == 7'd0) begin
                        n_phase = (r_chunk_rem == 15'd0) ? PH_CTRL_LO : PH_RUNHDR;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_cnt       <= 3'd0;
            r_low       <= 8'd0;
            r_hw0       <= 16'd0;
            r_hw1       <= 16'd0;
            r_hw2       <= 16'd0;
            r_width     <= 16'd0;
            r_rle       <= 1'b0;
            r_chunk_rem <= 15'd0;
            r_run_rem   <= 7'd0;
            r_xoff      <= 16'd0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_low       <= n_low;
            r_hw0       <= n_hw0;
            r_hw1       <= n_hw1;
            r_hw2       <= n_hw2;
            r_width     <= n_width;
            r_rle       <= n_rle;
            r_chunk_rem <= n_chunk_rem;
            r_run_rem   <= n_run_rem;
            r_xoff      <= n_xoff;
        end
    end

endmodule
`default_nettype wire

// ===== design/drsd_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drsd_cmd_fifo: command queue
// Short queue between the parser and the span engine.
// ----------------------------------------------------------------------------
module drsd_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire drsd_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output drsd_pkg::t_cmd      o_cmd,
    output logic                o_full,
    output logic                o_empty
);
    import drsd_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + Q_AW'(1);
            if (do_pop)  r_rp <= r_rp + Q_AW'(1);
            r_cnt <= r_cnt + (Q_AW + 1)'(do_push) - (Q_AW + 1)'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ===== design/drsd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drsd_back: span engine
// Registered multiply for row offset and buffer size, then write pointer
// update, range check and a result queue.
// ----------------------------------------------------------------------------
module drsd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire drsd_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_empty,
    output logic                o_cmd_pop,
    input  wire logic           i_pop,
    output drsd_pkg::t_result   o_res,
    output logic                o_empty
);
    import drsd_pkg::*;

    logic                     r_a_valid;
    t_cmd                     r_a_cmd;
    logic signed [PROD_W-1:0] r_a_prod;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] r_ptr, n_ptr;
    logic [BS_W-1:0]          r_bufsize, n_bufsize;

    t_result                  r_oq [Q_DEPTH];
    logic [Q_AW-1:0]          r_oq_wp, r_oq_rp;
    logic [Q_AW:0]            r_oq_cnt;
    logic                     oq_full, oq_push, oq_pop;

    logic                     needs_out, advance, fire;
    t_result                  res;

    assign prod      = i_cmd.op_a * i_cmd.op_b;
    assign needs_out = (r_a_cmd.kind != CMD_SETPTR);
    assign oq_full   = (r_oq_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign advance   = !r_a_valid || !needs_out || !oq_full;
    assign fire      = r_a_valid && advance;
    assign o_cmd_pop = advance && !i_cmd_empty;
    assign oq_push   = fire && needs_out;
    assign o_empty   = (r_oq_cnt == '0);
    assign oq_pop    = i_pop && !o_empty;
    assign o_res     = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= !i_cmd_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_cmd  <= i_cmd;
            r_a_prod <= prod;
        end
    end

    always_comb begin
        logic signed [PROD_W-1:0] end_pos;
        logic signed [PROD_W-1:0] size_sum;
        logic signed [PROD_W-1:0] bs_ext;

        n_ptr     = r_ptr;
        n_bufsize = r_bufsize;
        res       = '0;
        end_pos   = r_ptr + PROD_W'(r_a_cmd.len);
        size_sum  = r_a_prod + PROD_W'(HDR_BYTES);
        bs_ext    = $signed(PROD_W'(r_bufsize));

        unique case (r_a_cmd.kind)
            CMD_HDR: begin
                res.dest_address = DEST_W'(r_a_cmd.x_off[2:0]);
                res.span_length  = r_a_cmd.len;
                res.pixel_value  = r_a_cmd.val;
                if (r_a_cmd.fin) begin
                    if (r_a_cmd.op_a <= 0 || r_a_cmd.op_b <= 0) begin
                        n_bufsize = HDR_SIZE;
                    end else if (size_sum > $signed(PROD_W'(BUF_CAP))) begin
                        n_bufsize = BUF_CAP;
                    end else begin
                        n_bufsize = size_sum[BS_W-1:0];
                    end
                end
            end
            CMD_PIX: begin
                res.dest_address = r_ptr[DEST_W-1:0] & DEST_MASK;
                res.span_length  = r_a_cmd.len;
                res.pixel_value  = r_a_cmd.val;
                res.out_of_range = r_ptr[PROD_W-1] || (end_pos > bs_ext);
                n_ptr            = end_pos;
            end
            CMD_SETPTR: begin
                n_ptr = r_a_prod + PROD_W'($signed(r_a_cmd.x_off))
                        + PROD_W'(HDR_BYTES);
            end
            CMD_DONE: begin
                res.image_done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_bufsize <= '0;
        end else if (fire) begin
            r_ptr     <= n_ptr;
            r_bufsize <= n_bufsize;
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (oq_push) r_oq_wp <= r_oq_wp + Q_AW'(1);
            if (oq_pop)  r_oq_rp <= r_oq_rp + Q_AW'(1);
            r_oq_cnt <= r_oq_cnt + (Q_AW + 1)'(oq_push) - (Q_AW + 1)'(oq_pop);
        end
    end

endmodule
`default_nettype wire

// ===== design/delta_rle_sprite_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delta_rle_sprite_decoder: delta/RLE sprite stream to write spans
// Parser front end, command queue and span engine with a result queue.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while full is low and gives at most one
// write span per byte; a fill run comes out as one span. The command queue
// is written at the accepting edge; the registered multiplier (row offset
// and buffer size) is loaded from it, and then the pointer update and range
// check write into the result queue. Both queues hold four entries; push
// sees full while the command queue is full, which happens only when
// results are not popped.
// ----------------------------------------------------------------------------
module delta_rle_sprite_decoder (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [7:0]                   i_data_byte,
    input  wire logic                         i_image_start,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [drsd_pkg::DEST_W-1:0]       o_dest_address,
    output logic [drsd_pkg::LEN_W-1:0]        o_span_length,
    output logic [7:0]                        o_pixel_value,
    output logic                              o_out_of_range,
    output logic                              o_image_done
);
    import drsd_pkg::*;

    t_cmd    front_cmd, q_cmd;
    logic    cmd_push, cmd_pop, cmd_empty;
    t_result res;

    drsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (push && !full),
        .i_data_byte   (i_data_byte),
        .i_image_start (i_image_start),
        .o_cmd         (front_cmd),
        .o_cmd_push    (cmd_push)
    );

    drsd_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .i_pop   (cmd_pop),
        .o_cmd   (q_cmd),
        .o_full  (full),
        .o_empty (cmd_empty)
    );

    drsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_res       (res),
        .o_empty     (empty)
    );

    assign o_dest_address = res.dest_address;
    assign o_span_length  = res.span_length;
    assign o_pixel_value  = res.pixel_value;
    assign o_out_of_range = res.out_of_range;
    assign o_image_done   = res.image_done;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !cmd_push)
        else $error("command pushed into a full queue");

    a_done_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_image_done) |-> (o_span_length == '0 && !o_out_of_range))
        else $error("end result carries span data");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

endmodule
`default_nettype wire
